/* rtl/spq_pkg.sv */
// Shared constants and types for the sorted-array priority queue.
package spq_pkg;

  localparam int unsigned QueueDepth   = 16;
  localparam int unsigned PayloadBits  = 32;
  localparam int unsigned PriorityBits = 8;

  localparam int unsigned KindBits = 2;

  // Operation codes carried on the input tuser
  localparam logic [KindBits-1:0] KIND_INSERT = 2'd0;
  localparam logic [KindBits-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KindBits-1:0] KIND_STATUS = 2'd2;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // accepted insert
    logic rem;  // accepted remove
  } cell_ctrl_t;

endpackage

/* rtl/spq_cell.sv */
// One slot of the sorted chain: holds an entry, shifts to or from its neighbors.
module spq_cell #(
  parameter int unsigned PAYLOAD_BITS  = spq_pkg::PayloadBits,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PriorityBits
) (
  input  logic                     clk_i,
  input  spq_pkg::cell_ctrl_t      ctrl_i,
  input  logic                     occ_i,       // slot holds a live entry
  input  logic [PAYLOAD_BITS-1:0]  new_pay_i,
  input  logic [PRIORITY_BITS-1:0] new_prio_i,
  input  logic                     prev_below_i, // upper neighbor yields to new entry
  input  logic [PAYLOAD_BITS-1:0]  prev_pay_i,
  input  logic [PRIORITY_BITS-1:0] prev_prio_i,
  input  logic [PAYLOAD_BITS-1:0]  next_pay_i,
  input  logic [PRIORITY_BITS-1:0] next_prio_i,
  output logic                     below_o,     // new entry lands here or above
  output logic [PAYLOAD_BITS-1:0]  pay_o,
  output logic [PRIORITY_BITS-1:0] prio_o,
  output logic [PAYLOAD_BITS-1:0]  pay_d_o,
  output logic [PRIORITY_BITS-1:0] prio_d_o
);

  logic [PAYLOAD_BITS-1:0]  pay_q, pay_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;

  // strict compare keeps equal priorities in arrival order
  assign below_o = !occ_i || (prio_q < new_prio_i);

  always_comb begin
    pay_d  = pay_q;
    prio_d = prio_q;
    if (ctrl_i.ins && below_o) begin
      if (prev_below_i) begin
        pay_d  = prev_pay_i;
        prio_d = prev_prio_i;
      end else begin
        pay_d  = new_pay_i;
        prio_d = new_prio_i;
      end
    end else if (ctrl_i.rem) begin
      pay_d  = next_pay_i;
      prio_d = next_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q  <= pay_d;
    prio_q <= prio_d;
  end

  assign pay_o    = pay_q;
  assign prio_o   = prio_q;
  assign pay_d_o  = pay_d;
  assign prio_d_o = prio_d;

endmodule

/* rtl/sorted_array_priority_queue.sv */
// Top level of the sorted-array priority queue: cell chain, occupancy, result register.
// An accepted item's result is captured in the output register.
// Throughput: one item per cycle while the output is not stalled; every cell updates
// in parallel each cycle, so the single-step shift sets the rate, not QUEUE_DEPTH.
// Reset: rst_ni clears the occupancy and the output valid; slot contents are
// not cleared, only slots below the occupancy are ever read.
module sorted_array_priority_queue #(
  parameter int unsigned QUEUE_DEPTH   = spq_pkg::QueueDepth,
  parameter int unsigned PAYLOAD_BITS  = spq_pkg::PayloadBits,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PriorityBits,
  localparam int unsigned CntW     = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned InBits   = PAYLOAD_BITS + PRIORITY_BITS,
  localparam int unsigned InW      = ((InBits + 7) / 8) * 8,
  localparam int unsigned OutBits  = 4 + PAYLOAD_BITS + PRIORITY_BITS + CntW,
  localparam int unsigned OutW     = ((OutBits + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // from bit 0: item_payload, item_priority, zero fill
  input  logic [InW-1:0]               s_axis_tdata_i,
  // kind
  input  logic [spq_pkg::KindBits-1:0] s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // from bit 0: accepted, top_valid, top_payload, top_priority, entry_count,
  // is_full, is_empty, zero fill
  output logic [OutW-1:0]              m_axis_tdata_o
);

  // ---------------------------------------------------------------------------
  // Input decode. Slot 0 is the head (highest priority); entries are kept in
  // descending priority, equal priorities in arrival order.
  // ---------------------------------------------------------------------------
  logic                     in_fire;
  logic [PAYLOAD_BITS-1:0]  in_pay;
  logic [PRIORITY_BITS-1:0] in_prio;
  logic                     is_ins, is_rem;
  logic                     full, empty;
  logic                     accepted;
  spq_pkg::cell_ctrl_t      ctrl;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;

  // result register frees up when the downstream takes it
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_pay  = s_axis_tdata_i[PAYLOAD_BITS-1:0];
  assign in_prio = s_axis_tdata_i[InBits-1:PAYLOAD_BITS];

  assign is_ins = (s_axis_tuser_i == spq_pkg::KIND_INSERT);
  assign is_rem = (s_axis_tuser_i == spq_pkg::KIND_REMOVE);
  assign full   = (count_q == CntW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);

  // status read and the unused code are always accepted
  assign accepted = is_ins ? !full : (is_rem ? !empty : 1'b1);

  assign ctrl.ins = in_fire && is_ins && !full;
  assign ctrl.rem = in_fire && is_rem && !empty;

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain. On insert, cells whose entry ranks below the new one shift one
  // place toward the tail and the first of them takes the new entry. On remove,
  // every cell takes its tail-side neighbor.
  // ---------------------------------------------------------------------------
  logic [PAYLOAD_BITS-1:0]  pay   [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prio  [QUEUE_DEPTH];
  logic                     below [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  head_pay_d [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] head_prio_d [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     occ;
    logic                     prev_below;
    logic [PAYLOAD_BITS-1:0]  prev_pay, next_pay;
    logic [PRIORITY_BITS-1:0] prev_prio, next_prio;

    assign occ = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_below = 1'b0;
      assign prev_pay   = in_pay;
      assign prev_prio  = in_prio;
    end else begin : g_body
      assign prev_below = below[i-1];
      assign prev_pay   = pay[i-1];
      assign prev_prio  = prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      // tail slot is dropped on remove; its content no longer counts
      assign next_pay  = pay[i];
      assign next_prio = prio[i];
    end else begin : g_mid
      assign next_pay  = pay[i+1];
      assign next_prio = prio[i+1];
    end

    spq_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .new_pay_i   (in_pay),
      .new_prio_i  (in_prio),
      .prev_below_i(prev_below),
      .prev_pay_i  (prev_pay),
      .prev_prio_i (prev_prio),
      .next_pay_i  (next_pay),
      .next_prio_i (next_prio),
      .below_o     (below[i]),
      .pay_o       (pay[i]),
      .prio_o      (prio[i]),
      .pay_d_o     (head_pay_d[i]),
      .prio_d_o    (head_prio_d[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Result register: status after the step, head taken from slot 0's next value.
  // ---------------------------------------------------------------------------
  logic                     res_acc_q, res_tv_q, res_full_q, res_empty_q;
  logic [PAYLOAD_BITS-1:0]  res_pay_q;
  logic [PRIORITY_BITS-1:0] res_prio_q;
  logic [CntW-1:0]          res_cnt_q;
  logic                     top_valid_d;

  assign top_valid_d = (count_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_acc_q   <= accepted;
      res_tv_q    <= top_valid_d;
      res_pay_q   <= top_valid_d ? head_pay_d[0] : '0;
      res_prio_q  <= top_valid_d ? head_prio_d[0] : '0;
      res_cnt_q   <= count_d;
      res_full_q  <= (count_d == CntW'(QUEUE_DEPTH));
      res_empty_q <= !top_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutW - OutBits){1'b0}}, res_empty_q, res_full_q, res_cnt_q,
                            res_prio_q, res_pay_q, res_tv_q, res_acc_q};

endmodule
